FILE: design/lsv_pkg.sv
// Shared types, constants and helper functions for the VLAN learning switch.
// No dependencies; every other file of the block imports this package.

package lsv_pkg;

  // Sizing
  localparam int PORTS         = 4;
  localparam int TABLE_ENTRIES = 16;
  localparam int TRUNK_SLOTS   = 4;
  localparam int TRUNK_REGS    = 4;

  // Field widths
  localparam int MAC_W     = 48;
  localparam int VID_W     = 12;
  localparam int PORT_W    = 2;
  localparam int CNT_W     = PORT_W + 1;
  localparam int MODE_W    = 2;
  localparam int ACT_W     = 2;
  localparam int LS_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 48;
  localparam int MODES_W   = 8;

  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  // Port modes
  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACCESS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRUNK   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_L3      = 2'd3;

  // Egress actions
  localparam logic [ACT_W-1:0] ACT_DROP  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PASS  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UNTAG = 2'd2;

  // Learning outcome
  localparam logic [LS_W-1:0] LS_SAME  = 2'd0;
  localparam logic [LS_W-1:0] LS_NEW   = 2'd1;
  localparam logic [LS_W-1:0] LS_MOVED = 2'd2;
  localparam logic [LS_W-1:0] LS_FULL  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PORT_MODES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCESS_VLANS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRUNK_P0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRUNK_P1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRUNK_P2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRUNK_P3     = 3'd5;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SRC   = 6'b000010,
    ST_LEARN = 6'b000100,
    ST_DST   = 6'b001000,
    ST_PLAN  = 6'b010000,
    ST_EMIT  = 6'b100000
  } lsv_state_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic latch;    // capture the input beat
    logic src_cmp;  // compare source against the table
    logic learn;    // write the table
    logic dst_cmp;  // compare destination against the table
    logic plan;     // pick unicast port or first flood port
    logic emit;     // load one result into the output register
  } lsv_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic none;      // frame yields no result
    logic out_free;  // output register can take a result
    logic last;      // current result is the final one
  } lsv_stat_t;

  // Isolate the lowest set bit
  function automatic logic [TABLE_ENTRIES-1:0] lowest_one(
      input logic [TABLE_ENTRIES-1:0] vec);
    return vec & (~vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});
  endfunction

  // Egress decision for one port
  function automatic logic [ACT_W-1:0] egress_action(
      input logic [MODE_W-1:0]   mode,
      input logic [VID_W-1:0]    avid,
      input logic [CFG_W-1:0]    trunk,
      input logic                tag_bit,
      input logic [VID_W-1:0]    vid);
    logic [ACT_W-1:0] act;
    logic             hit;
    act = ACT_DROP;
    hit = 1'b0;
    for (int s = 0; s < TRUNK_SLOTS; s++) begin
      if (trunk[s*VID_W +: VID_W] == vid) hit = 1'b1;
    end
    case (mode)
      MODE_ACCESS: begin
        if (!tag_bit) act = (avid == '0) ? ACT_PASS : ACT_DROP;
        else act = (avid == vid) ? ACT_UNTAG : ACT_DROP;
      end
      MODE_TRUNK: begin
        act = (tag_bit && vid != '0 && hit) ? ACT_PASS : ACT_DROP;
      end
      default: act = ACT_DROP;
    endcase
    return act;
  endfunction

endpackage

FILE: design/lsv_if.sv
// Channel interfaces of the VLAN learning switch: header in, decision out, config.
// Depends on lsv_pkg for field widths.

interface lsv_in_if import lsv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MAC_W-1:0]     src_mac;
  logic [MAC_W-1:0]     dst_mac;
  logic [PORT_W-1:0]    in_port;
  logic                 tagged_req;
  logic [VID_W-1:0]     vlan_id;

  modport source (output valid, src_mac, dst_mac, in_port, tagged_req, vlan_id,
                  input ready);
  modport sink   (input valid, src_mac, dst_mac, in_port, tagged_req, vlan_id,
                  output ready);
endinterface

interface lsv_out_if import lsv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PORT_W-1:0]    out_port;
  logic [ACT_W-1:0]     action;
  logic                 flooded;
  logic [LS_W-1:0]      learn_status;
  logic                 last;

  modport source (output valid, out_port, action, flooded, learn_status, last,
                  input ready);
  modport sink   (input valid, out_port, action, flooded, learn_status, last,
                  output ready);
endinterface

interface lsv_cfg_if import lsv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/lsv_ctrl.sv
// Sequencer of the VLAN learning switch: steps one frame through learn,
// lookup and result emission. Depends on lsv_pkg.

module lsv_ctrl import lsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lsv_stat_t stat_i,
  output lsv_cmd_t  cmd_o
);

  lsv_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_SRC;
        end
      end
      ST_SRC: begin
        cmd_o.src_cmp = 1'b1;
        state_d       = ST_LEARN;
      end
      ST_LEARN: begin
        cmd_o.learn = 1'b1;
        state_d     = ST_DST;
      end
      ST_DST: begin
        cmd_o.dst_cmp = 1'b1;
        state_d       = ST_PLAN;
      end
      ST_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.none) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/lsv_datapath.sv
// Datapath of the VLAN learning switch: config registers, address table,
// parallel compares, egress filter and output register. Depends on lsv_pkg.

module lsv_datapath import lsv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // header beat
  input  logic [MAC_W-1:0]     src_mac_i,
  input  logic [MAC_W-1:0]     dst_mac_i,
  input  logic [PORT_W-1:0]    in_port_i,
  input  logic                 tagged_req_i,
  input  logic [VID_W-1:0]     vlan_id_i,
  // config write
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // sequencer
  input  lsv_cmd_t             cmd_i,
  output lsv_stat_t            stat_o,
  // decision beat
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PORT_W-1:0]    out_port_o,
  output logic [ACT_W-1:0]     action_o,
  output logic                 flooded_o,
  output logic [LS_W-1:0]      learn_status_o,
  output logic                 last_o
);

  // Configuration registers
  logic [MODES_W-1:0] port_modes_q;
  logic [CFG_W-1:0]   access_vlans_q;
  logic [CFG_W-1:0]   trunk_q [TRUNK_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_modes_q   <= '0;
      access_vlans_q <= '0;
      for (int r = 0; r < TRUNK_REGS; r++) trunk_q[r] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PORT_MODES:   port_modes_q   <= cfg_data_i[MODES_W-1:0];
        REG_ACCESS_VLANS: access_vlans_q <= cfg_data_i;
        REG_TRUNK_P0:     trunk_q[0]     <= cfg_data_i;
        REG_TRUNK_P1:     trunk_q[1]     <= cfg_data_i;
        REG_TRUNK_P2:     trunk_q[2]     <= cfg_data_i;
        REG_TRUNK_P3:     trunk_q[3]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured header
  logic [MAC_W-1:0]  src_q, dst_q;
  logic [PORT_W-1:0] inp_q;
  logic              tag_q;
  logic [VID_W-1:0]  vid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      src_q <= src_mac_i;
      dst_q <= dst_mac_i;
      inp_q <= in_port_i;
      tag_q <= tagged_req_i;
      vid_q <= vlan_id_i;
    end
  end

  // Address table
  logic [TABLE_ENTRIES-1:0] ent_valid_q;
  logic [MAC_W-1:0]         ent_mac_q  [TABLE_ENTRIES];
  logic [PORT_W-1:0]        ent_port_q [TABLE_ENTRIES];

  // Compare results
  logic [TABLE_ENTRIES-1:0] src_hit_q, free_q, dst_hit_q;
  logic                     bcast_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.src_cmp) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        src_hit_q[i] <= ent_valid_q[i] && (ent_mac_q[i] == src_q);
        free_q[i]    <= !ent_valid_q[i];
      end
    end
    if (cmd_i.dst_cmp) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        dst_hit_q[i] <= ent_valid_q[i] && (ent_mac_q[i] == dst_q);
      end
      bcast_q <= (dst_q == MAC_BCAST);
    end
  end

  // Learning decision
  logic [TABLE_ENTRIES-1:0] src_oh, free_oh, port_eq;
  logic                     src_known, same_port, has_free;
  logic [LS_W-1:0]          ls_d, ls_q;

  always_comb begin
    src_oh    = lowest_one(src_hit_q);
    free_oh   = lowest_one(free_q);
    for (int i = 0; i < TABLE_ENTRIES; i++) port_eq[i] = (ent_port_q[i] == inp_q);
    src_known = |src_hit_q;
    same_port = |(src_oh & port_eq);
    has_free  = |free_q;
    if (src_known) ls_d = same_port ? LS_SAME : LS_MOVED;
    else if (has_free) ls_d = LS_NEW;
    else ls_d = LS_FULL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
    end else if (cmd_i.learn && !src_known) begin
      ent_valid_q <= ent_valid_q | free_oh;
    end
  end

  // Write mac and port; a move rewrites only the port
  always_ff @(posedge clk_i) begin
    if (cmd_i.learn) begin
      ls_q <= ls_d;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (src_known && src_oh[i]) begin
          ent_port_q[i] <= inp_q;
        end else if (!src_known && free_oh[i]) begin
          ent_mac_q[i]  <= src_q;
          ent_port_q[i] <= inp_q;
        end
      end
    end
  end

  // Resolve destination: unicast port or first flood port
  logic [TABLE_ENTRIES-1:0] dst_oh;
  logic [PORT_W-1:0]        uport;
  logic                     flood_d, flood_q, none_q;
  logic [CNT_W-1:0]         inp_x, first_port, cur_q;
  logic [CNT_W-1:0]         nxt_a, nxt_port;

  always_comb begin
    dst_oh = lowest_one(dst_hit_q);
    uport  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      uport = uport | (dst_oh[i] ? ent_port_q[i] : '0);
    end
    flood_d    = bcast_q || !(|dst_hit_q);
    inp_x      = {1'b0, inp_q};
    first_port = (inp_x == '0) ? CNT_W'(1) : '0;
    nxt_a      = cur_q + CNT_W'(1);
    nxt_port   = (nxt_a == inp_x) ? nxt_a + CNT_W'(1) : nxt_a;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      flood_q <= flood_d;
      none_q  <= !flood_d && ({1'b0, uport} >= CNT_W'(PORTS));
      cur_q   <= flood_d ? first_port : {1'b0, uport};
    end else if (cmd_i.emit) begin
      cur_q   <= nxt_port;
    end
  end

  // Egress decision for the current port
  logic [PORT_W-1:0] cur_port;
  logic [MODE_W-1:0] mode_sel;
  logic [VID_W-1:0]  avid_sel;
  logic [ACT_W-1:0]  act;
  logic              last_now;

  always_comb begin
    cur_port = cur_q[PORT_W-1:0];
    mode_sel = port_modes_q[cur_port*MODE_W +: MODE_W];
    avid_sel = access_vlans_q[cur_port*VID_W +: VID_W];
    act      = egress_action(mode_sel, avid_sel, trunk_q[cur_port], tag_q, vid_q);
    last_now = !flood_q || (nxt_port >= CNT_W'(PORTS));
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_port_o     <= cur_port;
      action_o       <= act;
      flooded_o      <= flood_q;
      learn_status_o <= ls_q;
      last_o         <= last_now;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.none     = none_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.last     = last_now;

endmodule

FILE: design/l2_learning_switch_vlan_forwarder.sv
// Top level of the layer-2 learning switch with 802.1Q egress filtering.
// Depends on lsv_pkg, lsv_if, lsv_ctrl and lsv_datapath.
//
// Usage:
//   in_i   carries one frame header per beat: source and destination MAC,
//          ingress port, tag flag and VLAN id.
//   out_o  carries egress decisions: one per learned unicast destination,
//          one per other port when flooding; last marks the frame's final beat.
//   cfg_i  writes port modes, access VLANs and trunk lists; always ready.
//          Write only while no frame is in flight.
// Sequence: a header beat is taken, then source compare, table write,
//   destination compare and port selection follow, one sequencer state
//   each; the first decision is registered and then shows on out_o.
// Flow: R decisions per frame (1 to 3), issued by the sequencer walking one
//   egress port per cycle through the single filter unit while the output
//   register can take a result. The next header is taken while the final
//   decision still waits in the output register.
// Reset: clears the configuration and all table valid bits; entries come
//   free at once, with no clearing pass.
// Stall: while out_o is held, the sequencer pauses at the pending decision
//   and in_i stays not ready until the frame's last decision is loaded.

module l2_learning_switch_vlan_forwarder import lsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lsv_in_if.sink    in_i,
  lsv_out_if.source out_o,
  lsv_cfg_if.sink   cfg_i
);

  lsv_cmd_t  cmd;
  lsv_stat_t stat;

  assign cfg_i.ready = 1'b1;

  lsv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsv_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .src_mac_i      (in_i.src_mac),
    .dst_mac_i      (in_i.dst_mac),
    .in_port_i      (in_i.in_port),
    .tagged_req_i   (in_i.tagged_req),
    .vlan_id_i      (in_i.vlan_id),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_port_o     (out_o.out_port),
    .action_o       (out_o.action),
    .flooded_o      (out_o.flooded),
    .learn_status_o (out_o.learn_status),
    .last_o         (out_o.last)
  );

endmodule

FILE: design/lsv_checker.sv
// Port-level checks for the VLAN learning switch, bound to the top level.
// Depends on lsv_pkg for action codes and field widths.

module lsv_checker import lsv_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [ACT_W-1:0]  out_action_i,
  input logic              out_flooded_i,
  input logic              out_last_i
);

  // Hold a decision beat until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("decision beat dropped before it was taken");

  // Block new headers while a frame is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("header taken while the previous frame is in work");

  // Close a unicast frame with its single decision
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_flooded_i |-> out_last_i)
    else $error("unicast decision not marked last");

  // Emit only defined actions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_action_i == ACT_DROP || out_action_i == ACT_PASS ||
                     out_action_i == ACT_UNTAG))
    else $error("undefined egress action");

endmodule

bind l2_learning_switch_vlan_forwarder lsv_checker u_lsv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_action_i  (out_o.action),
  .out_flooded_i (out_o.flooded),
  .out_last_i    (out_o.last)
);

FILE: verif/lsv_decision_checker.sv
// Checker for the VLAN learning switch: watches the header, decision and config channels,
// predicts every egress decision and compares it with what the block sends.
// Depends on lsv_pkg and the channel interfaces in lsv_if.
`timescale 1ns / 100ps

module lsv_decision_checker import lsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lsv_in_if    hdr_mon,
  lsv_out_if   dec_mon,
  lsv_cfg_if   cfg_mon,
  output int   errors_o,
  output int   pending_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [ACT_W-1:0]  act;
    logic              flood;
    logic [LS_W-1:0]   learned;
    logic              last;
  } decision_t;

  // Shadow of the configuration registers
  logic [MODES_W-1:0] modes_q;
  logic [CFG_W-1:0]   access_q;
  logic [CFG_W-1:0]   trunk_q [TRUNK_REGS];

  // Shadow of the forwarding table
  logic              fdb_valid [TABLE_ENTRIES];
  logic [MAC_W-1:0]  fdb_mac   [TABLE_ENTRIES];
  logic [PORT_W-1:0] fdb_port  [TABLE_ENTRIES];

  decision_t decisions_due[$];
  decision_t seen;
  decision_t due;
  int        mismatches;

  assign errors_o = mismatches;

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic int fdb_lookup(input logic [MAC_W-1:0] mac);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (fdb_valid[i] && fdb_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // Learn the source: keep, move, or take the lowest free entry
  function automatic logic [LS_W-1:0] fdb_learn(input logic [MAC_W-1:0] mac,
                                                input logic [PORT_W-1:0] port);
    int hit;
    hit = fdb_lookup(mac);
    if (hit >= 0) begin
      if (fdb_port[hit] == port) return LS_SAME;
      fdb_port[hit] = port;
      return LS_MOVED;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!fdb_valid[i]) begin
        fdb_valid[i] = 1'b1;
        fdb_mac[i]   = mac;
        fdb_port[i]  = port;
        return LS_NEW;
      end
    end
    return LS_FULL;
  endfunction

  // Egress filter of one port under the current port mode
  function automatic logic [ACT_W-1:0] port_verdict(input logic [PORT_W-1:0] port,
                                                    input logic tag_bit,
                                                    input logic [VID_W-1:0] vid);
    logic [MODE_W-1:0] mode;
    logic [VID_W-1:0]  avid;
    logic              listed;
    mode   = modes_q[port*MODE_W +: MODE_W];
    avid   = access_q[port*VID_W +: VID_W];
    listed = 1'b0;
    for (int s = 0; s < TRUNK_SLOTS; s++) begin
      if (trunk_q[port][s*VID_W +: VID_W] == vid) listed = 1'b1;
    end
    if (mode == MODE_ACCESS) begin
      if (!tag_bit) return (avid == '0) ? ACT_PASS : ACT_DROP;
      return (avid == vid) ? ACT_UNTAG : ACT_DROP;
    end
    if (mode == MODE_TRUNK && tag_bit && vid != '0 && listed) return ACT_PASS;
    return ACT_DROP;
  endfunction

  // Learn, resolve the destination, and queue the decisions of one frame
  function automatic void plan_decisions(input logic [MAC_W-1:0]  src,
                                         input logic [MAC_W-1:0]  dst,
                                         input logic [PORT_W-1:0] inp,
                                         input logic              tag_bit,
                                         input logic [VID_W-1:0]  vid);
    logic [LS_W-1:0] status;
    int              hit;
    int              final_port;
    decision_t       d;
    status = fdb_learn(src, inp);
    hit = (dst == MAC_BCAST) ? -1 : fdb_lookup(dst);
    if (hit < 0) begin
      final_port = (inp == PORTS - 1) ? PORTS - 2 : PORTS - 1;
      for (int p = 0; p < PORTS; p++) begin
        if (p != inp) begin
          d.port    = PORT_W'(p);
          d.act     = port_verdict(PORT_W'(p), tag_bit, vid);
          d.flood   = 1'b1;
          d.learned = status;
          d.last    = (p == final_port);
          decisions_due.push_back(d);
        end
      end
    end else begin
      d.port    = fdb_port[hit];
      d.act     = port_verdict(fdb_port[hit], tag_bit, vid);
      d.flood   = 1'b0;
      d.learned = status;
      d.last    = 1'b1;
      decisions_due.push_back(d);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_q  = '0;
      access_q = '0;
      for (int r = 0; r < TRUNK_REGS; r++) trunk_q[r] = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) fdb_valid[i] = 1'b0;
      decisions_due.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      // Track register writes; indexes past the list are ignored
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_PORT_MODES: begin
            modes_q = cfg_mon.data[MODES_W-1:0];
          end
          REG_ACCESS_VLANS: begin
            access_q = cfg_mon.data;
          end
          REG_TRUNK_P0, REG_TRUNK_P1, REG_TRUNK_P2, REG_TRUNK_P3: begin
            trunk_q[cfg_mon.index - REG_TRUNK_P0] = cfg_mon.data;
          end
          default: begin
          end
        endcase
      end

      // Compare a decision beat with the oldest one due
      if (dec_mon.valid && dec_mon.ready) begin
        seen = '{dec_mon.out_port, dec_mon.action, dec_mon.flooded,
                 dec_mon.learn_status, dec_mon.last};
        if (decisions_due.size() == 0) begin
          flag_mismatch($sformatf(
            "unexpected decision: port=%0d act=%0d flood=%0d learn=%0d last=%0d",
            seen.port, seen.act, seen.flood, seen.learned, seen.last));
        end else begin
          due = decisions_due.pop_front();
          if (seen !== due) begin
            flag_mismatch($sformatf(
              {"decision mismatch: got port=%0d act=%0d flood=%0d learn=%0d last=%0d,",
               " exp port=%0d act=%0d flood=%0d learn=%0d last=%0d"},
              seen.port, seen.act, seen.flood, seen.learned, seen.last,
              due.port, due.act, due.flood, due.learned, due.last));
          end
        end
      end

      // Predict the decisions of an accepted header
      if (hdr_mon.valid && hdr_mon.ready) begin
        plan_decisions(hdr_mon.src_mac, hdr_mon.dst_mac, hdr_mon.in_port,
                       hdr_mon.tagged_req, hdr_mon.vlan_id);
      end

      pending_o <= decisions_due.size();
    end
  end

endmodule

FILE: verif/tb_l2_learning_switch_vlan_forwarder.sv
// Testbench top for the VLAN learning switch: clock, reset, header and config stimulus,
// decision-side back-pressure, watchdog and verdict. Checking lives in lsv_decision_checker.
// Depends on lsv_pkg, lsv_if and the block itself.
`timescale 1ns / 100ps

module tb_l2_learning_switch_vlan_forwarder;
  import lsv_pkg::*;

  localparam int IDLE_PCT       = 27;
  localparam int SINK_HOLD      = 60;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int POOL_SIZE      = 12;

  // Indexes past the register list; writes there must have no effect
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_TRUNK_P3 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_TRUNK_P3 + 3'd2;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lsv_in_if  hdr_if ();
  lsv_out_if dec_if ();
  lsv_cfg_if cfg_if ();

  int errors;
  int pending;
  int idle_cycles = 0;

  bit no_idle   = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  logic [MAC_W-1:0] mac_pool [POOL_SIZE];
  logic [CFG_W-1:0] access_cfg;
  logic [CFG_W-1:0] trunk_cfg [TRUNK_REGS];

  l2_learning_switch_vlan_forwarder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (hdr_if),
    .out_o  (dec_if),
    .cfg_i  (cfg_if)
  );

  lsv_decision_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hdr_mon   (hdr_if),
    .dec_mon   (dec_if),
    .cfg_mon   (cfg_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if ((hdr_if.valid && hdr_if.ready) || (dec_if.valid && dec_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Decision sink: random back-pressure, one long hold-off on request
  initial begin
    dec_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        dec_if.ready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        dec_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [MAC_W-1:0] mac;
    mac[31:0]  = $urandom;
    mac[47:32] = 16'($urandom_range(0, 16'hFFFF));
    return mac;
  endfunction

  // Four VLAN slots, some empty, many from a small set so ports overlap
  function automatic logic [CFG_W-1:0] rand_vlan_list();
    logic [CFG_W-1:0] list;
    for (int s = 0; s < TRUNK_SLOTS; s++) begin
      case ($urandom_range(0, 3))
        0:       list[s*VID_W +: VID_W] = '0;
        1:       list[s*VID_W +: VID_W] = VID_W'($urandom_range(0, (1 << VID_W) - 1));
        default: list[s*VID_W +: VID_W] = VID_W'($urandom_range(1, 8));
      endcase
    end
    return list;
  endfunction

  // VLAN id biased toward values present in the current configuration
  function automatic logic [VID_W-1:0] pick_vid();
    int slot;
    int roll;
    slot = $urandom_range(0, TRUNK_SLOTS - 1);
    roll = $urandom_range(0, 9);
    if (roll < TRUNK_REGS) return trunk_cfg[roll][slot*VID_W +: VID_W];
    if (roll == TRUNK_REGS) return access_cfg[slot*VID_W +: VID_W];
    if (roll == TRUNK_REGS + 1) return '0;
    if (roll == TRUNK_REGS + 2) return '1;
    return VID_W'($urandom_range(0, (1 << VID_W) - 1));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Write every register, upper bits of the mode word random, then both spare indexes
  task automatic load_cfg(input logic [MODES_W-1:0] modes, input logic [CFG_W-1:0] acc,
                          input logic [CFG_W-1:0] t0, input logic [CFG_W-1:0] t1,
                          input logic [CFG_W-1:0] t2, input logic [CFG_W-1:0] t3);
    access_cfg   = acc;
    trunk_cfg[0] = t0;
    trunk_cfg[1] = t1;
    trunk_cfg[2] = t2;
    trunk_cfg[3] = t3;
    write_reg(REG_PORT_MODES, CFG_W'({rand_mac(), modes}));
    write_reg(REG_ACCESS_VLANS, acc);
    write_reg(REG_TRUNK_P0, t0);
    write_reg(REG_TRUNK_P1, t1);
    write_reg(REG_TRUNK_P2, t2);
    write_reg(REG_TRUNK_P3, t3);
    write_reg(REG_SPARE_LO, rand_mac());
    write_reg(REG_SPARE_HI, rand_mac());
    cfg_if.valid <= 1'b0;
  endtask

  // Offer one header beat after an optional gap; return once it is taken
  task automatic offer_hdr(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                           input logic [PORT_W-1:0] port, input logic tag_bit,
                           input logic [VID_W-1:0] vid);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      hdr_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    hdr_if.valid      <= 1'b1;
    hdr_if.src_mac    <= src;
    hdr_if.dst_mac    <= dst;
    hdr_if.in_port    <= port;
    hdr_if.tagged_req <= tag_bit;
    hdr_if.vlan_id    <= vid;
    do @(posedge clk_i); while (!hdr_if.ready);
  endtask

  // Random header; narrow keeps sources in the pool, wide mostly brings new ones
  task automatic offer_random(input bit wide);
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [PORT_W-1:0] port;
    logic              tag_bit;
    int                roll;
    roll = $urandom_range(0, 99);
    src  = (wide && roll < 70) ? rand_mac() : mac_pool[$urandom_range(0, POOL_SIZE - 1)];
    roll = $urandom_range(0, 99);
    if (roll < 55) dst = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (roll < 75) dst = MAC_BCAST;
    else dst = rand_mac();
    port    = PORT_W'($urandom_range(0, PORTS - 1));
    tag_bit = 1'($urandom_range(0, 1));
    offer_hdr(src, dst, port, tag_bit, pick_vid());
  endtask

  // Hold the sender until every decision is out and the block has settled
  task automatic wait_drained();
    hdr_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    hdr_if.valid      <= 1'b0;
    hdr_if.src_mac    <= '0;
    hdr_if.dst_mac    <= '0;
    hdr_if.in_port    <= '0;
    hdr_if.tagged_req <= 1'b0;
    hdr_if.vlan_id    <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_PORT_MODES;
    cfg_if.data       <= '0;
    access_cfg = '0;
    for (int r = 0; r < TRUNK_REGS; r++) trunk_cfg[r] = '0;

    // Address zero and the broadcast address are sources like any other
    mac_pool[0] = '0;
    mac_pool[1] = MAC_BCAST;
    for (int m = 2; m < POOL_SIZE; m++) mac_pool[m] = rand_mac();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: every port of unknown mode drops
    offer_hdr(mac_pool[2], MAC_BCAST, 2'd0, 1'b0, '0);
    offer_hdr(mac_pool[3], mac_pool[2], 2'd3, 1'b1, '1);
    wait_drained();

    // Ports 0,1 access (VLAN unaware, VLAN 100), port 2 trunk, port 3 layer three
    load_cfg({MODE_L3, MODE_TRUNK, MODE_ACCESS, MODE_ACCESS},
             {12'hFFF, 12'd7, 12'd100, 12'd0},
             rand_mac(), rand_mac(),
             {12'd0, 12'hFFF, 12'd200, 12'd100},
             rand_mac());

    // New source, unicast to an access port, tagged VLAN 0 on an unaware port
    offer_hdr(mac_pool[4], mac_pool[2], 2'd1, 1'b1, 12'd0);
    // Move a source; unicast to layer three port
    offer_hdr(mac_pool[2], mac_pool[3], 2'd2, 1'b1, 12'd100);
    // Destination learned on the ingress port
    offer_hdr(mac_pool[2], mac_pool[2], 2'd2, 1'b1, 12'd100);
    // Unknown destination floods; trunk passes its listed VLAN 4095
    offer_hdr(mac_pool[5], mac_pool[7], 2'd3, 1'b1, 12'hFFF);
    // Trunk drops VLAN 0 even with an empty slot
    offer_hdr(mac_pool[5], mac_pool[2], 2'd3, 1'b1, 12'd0);
    offer_hdr(mac_pool[4], mac_pool[2], 2'd1, 1'b1, 12'd200);
    offer_hdr(mac_pool[4], mac_pool[2], 2'd1, 1'b1, 12'd300);
    // Untagged broadcast: unaware access port passes, others drop
    offer_hdr(mac_pool[6], MAC_BCAST, 2'd3, 1'b0, 12'd0);
    // Access port strips the tag of its own VLAN, drops untagged
    offer_hdr(mac_pool[6], mac_pool[4], 2'd0, 1'b1, 12'd100);
    offer_hdr(mac_pool[6], mac_pool[4], 2'd2, 1'b0, 12'd100);
    // Broadcast source is learned, then moved; broadcast destination still floods
    offer_hdr(MAC_BCAST, MAC_BCAST, 2'd1, 1'b0, 12'hFFF);
    offer_hdr(MAC_BCAST, MAC_BCAST, 2'd0, 1'b1, 12'd7);
    // All-zero address as source and destination
    offer_hdr(mac_pool[0], mac_pool[0], 2'd3, 1'b1, 12'd0);
    offer_hdr(mac_pool[0], mac_pool[0], 2'd1, 1'b0, 12'd0);
    // Untagged frame to a trunk; the VLAN field is ignored
    offer_hdr(mac_pool[2], mac_pool[6], 2'd0, 1'b0, 12'hFFF);

    // Random frames; sink holds off early on, then a stretch with no gaps
    for (int k = 0; k < 40; k++) begin
      if (k == 8) hold_req = 1'b1;
      no_idle = (k >= 20 && k < 35);
      offer_random(1'b0);
    end
    no_idle = 1'b0;
    wait_drained();

    // All ones everywhere: every port layer three
    load_cfg('1, '1, '1, '1, '1, '1);
    for (int k = 0; k < 8; k++) offer_random(1'b0);
    wait_drained();

    // All access ports on VLAN 4095, trunk lists empty
    load_cfg({PORTS{MODE_ACCESS}}, '1, '0, '0, '0, '0);
    for (int k = 0; k < 10; k++) offer_random(1'b0);
    wait_drained();

    // Random modes and lists
    load_cfg(MODES_W'($urandom_range(0, 255)), rand_vlan_list(), rand_vlan_list(),
             rand_vlan_list(), rand_vlan_list(), rand_vlan_list());
    for (int k = 0; k < 20; k++) offer_random(1'b0);
    wait_drained();

    // Fresh sources fill the table; later new ones are refused
    load_cfg(MODES_W'($urandom_range(0, 255)), rand_vlan_list(), rand_vlan_list(),
             rand_vlan_list(), rand_vlan_list(), rand_vlan_list());
    for (int k = 0; k < 25; k++) offer_random(1'b1);
    wait_drained();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
